FILE: design/sgaa_pkg.sv
// ----------------------------------------------------------------------------
// sgaa_pkg: shared types, codes and helpers for the alignment score block
// Beat payloads, action and register codes, and the 8-bit saturating
// arithmetic used by the cell recurrence.
// ----------------------------------------------------------------------------
package sgaa_pkg;

  localparam logic signed [7:0] SCORE_HI    = 8'sh7F;
  localparam logic signed [7:0] SCORE_LO    = 8'sh80;
  localparam logic signed [7:0] GAP_NEG_INF = 8'sh80;

  localparam logic [1:0] ACT_TABLE = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_DB    = 2'd2;

  localparam logic REG_GAP_OPEN   = 1'b0;
  localparam logic REG_GAP_EXTEND = 1'b1;

  localparam logic [6:0] GAP_OPEN_RST   = 7'd10;
  localparam logic [6:0] GAP_EXTEND_RST = 7'd1;

  typedef struct packed {
    logic [1:0]        action;
    logic [4:0]        row_symbol;
    logic [4:0]        col_symbol;
    logic signed [7:0] entry_value;
    logic [4:0]        symbol;
    logic              last;
  } in_t;

  typedef struct packed {
    logic signed [7:0] score;
    logic              saturated;
  } out_t;

  // Travels with one query row through the cell stages.
  typedef struct packed {
    logic valid;
    logic first;
    logic last_row;
  } row_tag_t;

  function automatic logic signed [7:0] clamp8(input logic signed [9:0] d);
    logic signed [7:0] r;
    if (d > 10'sd127) begin
      r = SCORE_HI;
    end else if (d < -10'sd128) begin
      r = SCORE_LO;
    end else begin
      r = d[7:0];
    end
    return r;
  endfunction

  function automatic logic signed [7:0] sub_sat(input logic signed [7:0] a,
                                               input logic [6:0] b);
    logic signed [9:0] d;
    d = {{2{a[7]}}, a} - {3'b000, b};
    return clamp8(d);
  endfunction

  function automatic logic signed [7:0] add_sat(input logic signed [7:0] a,
                                               input logic signed [7:0] b);
    logic signed [9:0] d;
    d = {{2{a[7]}}, a} + {{2{b[7]}}, b};
    return clamp8(d);
  endfunction

  function automatic logic signed [7:0] max8(input logic signed [7:0] a,
                                            input logic signed [7:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: design/semiglobal_affine_align_score.sv
// ----------------------------------------------------------------------------
// semiglobal_affine_align_score: semi-global affine-gap alignment score
// Table and query beats are taken while idle and leave busy low. A
// database beat sweeps the stored query one row per cycle through the
// shared cell unit: busy stays high for the sweep, and the score strobe
// (final database symbol only) rises as busy falls. The receiver cannot stall.
// Reset restores gap penalties and database state; no clearing pass.
// ----------------------------------------------------------------------------
module semiglobal_affine_align_score #(
  parameter int MAX_QUERY = 1024,
  parameter int ALPHABET  = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  sgaa_pkg::in_t       in_item,
  output logic                out_valid,
  output sgaa_pkg::out_t      out_result,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int IW    = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int LW    = $clog2(MAX_QUERY + 1);
  localparam int TDEP  = ALPHABET * ALPHABET;
  localparam int TAW   = $clog2(TDEP);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // Configuration registers
  logic [6:0] gap_open_r;
  logic [6:0] gap_extend_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_open_r   <= sgaa_pkg::GAP_OPEN_RST;
      gap_extend_r <= sgaa_pkg::GAP_EXTEND_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        sgaa_pkg::REG_GAP_OPEN:   gap_open_r   <= pwdata[6:0];
        sgaa_pkg::REG_GAP_EXTEND: gap_extend_r <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sgaa_pkg::REG_GAP_OPEN:   prdata = {25'd0, gap_open_r};
      sgaa_pkg::REG_GAP_EXTEND: prdata = {25'd0, gap_extend_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // Control state
  logic [1:0]          state_r, state_nxt;
  logic [LW-1:0]       qlen_r, qlen_nxt;
  logic                qdone_r, qdone_nxt;
  logic                fresh_r, fresh_nxt;
  logic signed [7:0]   best_r, best_nxt;
  logic                sat_r, sat_nxt;
  logic [IW-1:0]       rd_idx_r, rd_idx_nxt;
  logic [4:0]          db_sym_r;
  logic                db_last_r;
  logic                out_valid_r, out_valid_nxt;
  sgaa_pkg::out_t      out_result_r, out_result_nxt;

  logic                accept;
  logic                issue_last;
  logic [LW-1:0]       qpos;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start & ~busy;
  assign qpos   = qdone_r ? '0 : qlen_r;
  assign issue_last = ((LW'(rd_idx_r) + LW'(1)) == qlen_r);

  // Table RAM write side
  logic            tram_we;
  logic [TAW-1:0]  tram_waddr;
  logic [TAW-1:0]  tram_raddr;
  logic [7:0]      tram_rdata;

  assign tram_we = accept && (in_item.action == sgaa_pkg::ACT_TABLE) &&
                   (32'(in_item.row_symbol) < ALPHABET) &&
                   (32'(in_item.col_symbol) < ALPHABET);
  assign tram_waddr = TAW'(TAW'(in_item.row_symbol) * TAW'(ALPHABET)) +
                      TAW'(in_item.col_symbol);

  // Query RAM
  logic            qram_we;
  logic [4:0]      qram_rdata;

  assign qram_we = accept && (in_item.action == sgaa_pkg::ACT_QUERY) &&
                   (qpos < LW'(MAX_QUERY));

  // Column RAM: {H, horizontal gap} per row
  logic            cram_we;
  logic [15:0]     cram_wdata;
  logic [15:0]     cram_rdata;

  // Stage 1 pipeline registers (RAM read data valid in this stage)
  sgaa_pkg::row_tag_t s1_tag_r;
  logic [IW-1:0]      s1_idx_r;

  logic signed [7:0]  s1_west;
  logic signed [7:0]  s1_iw;
  logic signed [7:0]  s1_ins;
  logic               s1_zero;

  sgaa_pkg::row_tag_t s2_tag_r;
  logic [IW-1:0]      s2_idx_r;
  logic signed [7:0]  s2_west_r;
  logic signed [7:0]  s2_ins_r;
  logic               s2_zero_r;

  sgaa_pkg::row_tag_t cell_tag;
  logic [IW-1:0]      cell_idx;
  logic signed [7:0]  cell_h;
  logic signed [7:0]  cell_ins;

  always_comb begin
    s1_west = fresh_r ? 8'sd0 : cram_rdata[15:8];
    s1_iw   = fresh_r ? sgaa_pkg::GAP_NEG_INF : cram_rdata[7:0];
    s1_ins  = sgaa_pkg::max8(sgaa_pkg::sub_sat(s1_west, gap_open_r),
                             sgaa_pkg::sub_sat(s1_iw, gap_extend_r));
    s1_zero = (32'(qram_rdata) >= ALPHABET) || (32'(db_sym_r) >= ALPHABET);
    tram_raddr = TAW'(TAW'(qram_rdata) * TAW'(ALPHABET)) + TAW'(db_sym_r);
  end

  sgaa_ram #(.WIDTH(8), .DEPTH(TDEP)) u_tram (
    .clk   (clk),
    .we    (tram_we),
    .waddr (tram_waddr),
    .wdata (in_item.entry_value),
    .raddr (tram_raddr),
    .rdata (tram_rdata)
  );

  sgaa_ram #(.WIDTH(5), .DEPTH(MAX_QUERY)) u_qram (
    .clk   (clk),
    .we    (qram_we),
    .waddr (qpos[IW-1:0]),
    .wdata (in_item.symbol),
    .raddr (rd_idx_r),
    .rdata (qram_rdata)
  );

  sgaa_ram #(.WIDTH(16), .DEPTH(MAX_QUERY)) u_cram (
    .clk   (clk),
    .we    (cram_we),
    .waddr (cell_idx),
    .wdata (cram_wdata),
    .raddr (rd_idx_r),
    .rdata (cram_rdata)
  );

  sgaa_cell #(.IW(IW)) u_cell (
    .clk        (clk),
    .rst_n      (rst_n),
    .gap_open   (gap_open_r),
    .gap_extend (gap_extend_r),
    .in_tag     (s2_tag_r),
    .in_idx     (s2_idx_r),
    .in_west    (s2_west_r),
    .in_ins     (s2_ins_r),
    .in_zero    (s2_zero_r),
    .in_subst   (tram_rdata),
    .out_tag    (cell_tag),
    .out_idx    (cell_idx),
    .out_h      (cell_h),
    .out_ins    (cell_ins)
  );

  assign cram_we    = cell_tag.valid;
  assign cram_wdata = {cell_h, cell_ins};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else begin
      s1_tag_r.valid    <= (state_r == ST_RUN);
      s1_tag_r.first    <= (rd_idx_r == '0);
      s1_tag_r.last_row <= issue_last;
      s2_tag_r          <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r  <= rd_idx_r;
    s2_idx_r  <= s1_idx_r;
    s2_west_r <= s1_west;
    s2_ins_r  <= s1_ins;
    s2_zero_r <= s1_zero;
    if (accept) begin
      db_sym_r  <= in_item.symbol;
      db_last_r <= in_item.last;
    end
  end

  // Sequencer and running score
  always_comb begin
    state_nxt      = state_r;
    qlen_nxt       = qlen_r;
    qdone_nxt      = qdone_r;
    fresh_nxt      = fresh_r;
    best_nxt       = best_r;
    sat_nxt        = sat_r;
    rd_idx_nxt     = rd_idx_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_item.action == sgaa_pkg::ACT_QUERY) begin
            // a new query restarts the database
            if (qdone_r) begin
              fresh_nxt = 1'b1;
              best_nxt  = sgaa_pkg::GAP_NEG_INF;
              sat_nxt   = 1'b0;
            end
            qlen_nxt = (qpos < LW'(MAX_QUERY)) ? qpos + LW'(1) : qpos;
            qdone_nxt = in_item.last;
          end else if ((in_item.action == sgaa_pkg::ACT_DB) && qdone_r) begin
            rd_idx_nxt = '0;
            state_nxt  = ST_RUN;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_RUN: begin
        if (issue_last) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_idx_nxt = rd_idx_r + IW'(1);
        end
      end
      ST_DRAIN: ;
      default: state_nxt = ST_IDLE;
    endcase

    if (cell_tag.valid) begin
      if ((cell_h == sgaa_pkg::SCORE_LO) || (cell_h == sgaa_pkg::SCORE_HI)) begin
        sat_nxt = 1'b1;
      end
      if ((cell_tag.last_row || db_last_r) && (cell_h > best_r)) begin
        best_nxt = cell_h;
      end
      if (cell_tag.last_row) begin
        state_nxt = ST_IDLE;
        if (db_last_r) begin
          out_valid_nxt            = 1'b1;
          out_result_nxt.saturated = sat_nxt;
          out_result_nxt.score     = sat_nxt ? sgaa_pkg::SCORE_HI : best_nxt;
          // drop back to the start of a database
          fresh_nxt = 1'b1;
          best_nxt  = sgaa_pkg::GAP_NEG_INF;
          sat_nxt   = 1'b0;
        end else begin
          fresh_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      qlen_r      <= '0;
      qdone_r     <= 1'b0;
      fresh_r     <= 1'b1;
      best_r      <= sgaa_pkg::GAP_NEG_INF;
      sat_r       <= 1'b0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      qlen_r      <= qlen_nxt;
      qdone_r     <= qdone_nxt;
      fresh_r     <= fresh_nxt;
      best_r      <= best_nxt;
      sat_r       <= sat_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= out_result_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule

FILE: design/sgaa_ram.sv
// ----------------------------------------------------------------------------
// sgaa_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sgaa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/sgaa_cell.sv
// ----------------------------------------------------------------------------
// sgaa_cell: affine-gap cell unit
// Two stages shared by every query row: diagonal plus substitution, then the
// vertical gap recurrence that carries from one row to the next.
// ----------------------------------------------------------------------------
module sgaa_cell #(
  parameter int IW = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [6:0]                gap_open,
  input  logic [6:0]                gap_extend,
  input  sgaa_pkg::row_tag_t        in_tag,
  input  logic [IW-1:0]             in_idx,
  input  logic signed [7:0]         in_west,
  input  logic signed [7:0]         in_ins,
  input  logic                      in_zero,
  input  logic signed [7:0]         in_subst,
  output sgaa_pkg::row_tag_t        out_tag,
  output logic [IW-1:0]             out_idx,
  output logic signed [7:0]         out_h,
  output logic signed [7:0]         out_ins
);

  logic signed [7:0]  diag_r;
  logic signed [7:0]  diag;
  logic signed [7:0]  subst;
  logic signed [7:0]  hpre;

  sgaa_pkg::row_tag_t s3_tag_r;
  logic [IW-1:0]      s3_idx_r;
  logic signed [7:0]  s3_hpre_r;
  logic signed [7:0]  s3_ins_r;

  logic signed [7:0]  north_r;
  logic signed [7:0]  dprev_r;
  logic signed [7:0]  north;
  logic signed [7:0]  dprev;
  logic signed [7:0]  del;
  logic signed [7:0]  h;

  // Diagonal term and horizontal gap do not depend on the row above.
  always_comb begin
    diag  = in_tag.first ? 8'sd0 : diag_r;
    subst = in_zero ? 8'sd0 : in_subst;
    hpre  = sgaa_pkg::max8(sgaa_pkg::add_sat(diag, subst), in_ins);
  end

  always_ff @(posedge clk) begin
    if (in_tag.valid) begin
      diag_r <= in_west;
    end
    s3_idx_r  <= in_idx;
    s3_hpre_r <= hpre;
    s3_ins_r  <= in_ins;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_tag_r <= '0;
    end else begin
      s3_tag_r <= in_tag;
    end
  end

  // Vertical gap: carried from the row just finished.
  always_comb begin
    north = s3_tag_r.first ? 8'sd0 : north_r;
    dprev = s3_tag_r.first ? sgaa_pkg::GAP_NEG_INF : dprev_r;
    del   = sgaa_pkg::max8(sgaa_pkg::sub_sat(north, gap_open),
                           sgaa_pkg::sub_sat(dprev, gap_extend));
    h     = sgaa_pkg::max8(s3_hpre_r, del);
  end

  always_ff @(posedge clk) begin
    if (s3_tag_r.valid) begin
      north_r <= h;
      dprev_r <= del;
    end
  end

  assign out_tag = s3_tag_r;
  assign out_idx = s3_idx_r;
  assign out_h   = h;
  assign out_ins = s3_ins_r;

endmodule
